// ----- src/assert_macros.svh -----
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define MK_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mk assertion failed");

// next-cycle implication, ignored while in reset
`define MK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mk assertion failed");

// next-cycle implication that also holds across reset
`define MK_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mk assertion failed");

`endif

// ----- src/mk_pkg.sv -----
package mk_pkg;

  localparam int TICK_W    = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DOT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP   = 2'd3;

  localparam logic [TICK_W-1:0] DOT_RESET   = 12'd100;
  localparam logic [TICK_W-1:0] DASH_RESET  = 12'd600;
  localparam logic [TICK_W-1:0] SPACE_RESET = 12'd600;
  localparam logic [TICK_W-1:0] GAP_RESET   = 12'd1000;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_MARK = 4'b0010,
    PH_DARK = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_t;

  // decoded character: elements left-aligned, 1 = dash
  typedef struct packed {
    logic       known;
    logic       is_space;
    logic [4:0] bits;
    logic [2:0] len;
  } pattern_t;

  typedef struct packed {
    logic led_on;
    logic busy_res;
    logic rejected;
  } result_t;

endpackage

// ----- src/mk_ifs.sv -----
interface mk_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_code;

  modport source (output valid, output mode, output char_code, input ready);
  modport sink (input valid, input mode, input char_code, output ready);
endinterface

interface mk_rsp_if;
  logic valid;
  logic ready;
  logic led_on;
  logic busy_res;
  logic rejected;

  modport source (output valid, output led_on, output busy_res, output rejected,
                  input ready);
  modport sink (input valid, input led_on, input busy_res, input rejected,
                output ready);
endinterface

// ----- src/mk_decode.sv -----
module mk_decode (
  input  logic [7:0]        char_code,
  output mk_pkg::pattern_t  pattern
);

  always_comb begin
    pattern = '{known: 1'b1, is_space: 1'b0, bits: 5'b00000, len: 3'd0};
    case (char_code)
      "A": begin pattern.bits = 5'b01000; pattern.len = 3'd2; end
      "B": begin pattern.bits = 5'b10000; pattern.len = 3'd4; end
      "C": begin pattern.bits = 5'b10100; pattern.len = 3'd4; end
      "D": begin pattern.bits = 5'b10000; pattern.len = 3'd3; end
      "E": begin pattern.bits = 5'b00000; pattern.len = 3'd1; end
      "F": begin pattern.bits = 5'b00100; pattern.len = 3'd4; end
      "G": begin pattern.bits = 5'b11000; pattern.len = 3'd3; end
      "H": begin pattern.bits = 5'b00000; pattern.len = 3'd4; end
      "I": begin pattern.bits = 5'b00000; pattern.len = 3'd2; end
      "J": begin pattern.bits = 5'b01110; pattern.len = 3'd4; end
      "K": begin pattern.bits = 5'b10100; pattern.len = 3'd3; end
      "L": begin pattern.bits = 5'b01000; pattern.len = 3'd4; end
      "M": begin pattern.bits = 5'b11000; pattern.len = 3'd2; end
      "N": begin pattern.bits = 5'b10000; pattern.len = 3'd2; end
      "O": begin pattern.bits = 5'b11100; pattern.len = 3'd3; end
      "P": begin pattern.bits = 5'b01100; pattern.len = 3'd4; end
      "Q": begin pattern.bits = 5'b11010; pattern.len = 3'd4; end
      "R": begin pattern.bits = 5'b01000; pattern.len = 3'd3; end
      "S": begin pattern.bits = 5'b00000; pattern.len = 3'd3; end
      "T": begin pattern.bits = 5'b10000; pattern.len = 3'd1; end
      "U": begin pattern.bits = 5'b00100; pattern.len = 3'd3; end
      "V": begin pattern.bits = 5'b00010; pattern.len = 3'd4; end
      "W": begin pattern.bits = 5'b01100; pattern.len = 3'd3; end
      "X": begin pattern.bits = 5'b10010; pattern.len = 3'd4; end
      "Y": begin pattern.bits = 5'b10110; pattern.len = 3'd4; end
      "Z": begin pattern.bits = 5'b11000; pattern.len = 3'd4; end
      "0": begin pattern.bits = 5'b11111; pattern.len = 3'd5; end
      "1": begin pattern.bits = 5'b01111; pattern.len = 3'd5; end
      "2": begin pattern.bits = 5'b00111; pattern.len = 3'd5; end
      "3": begin pattern.bits = 5'b00011; pattern.len = 3'd5; end
      "4": begin pattern.bits = 5'b00001; pattern.len = 3'd5; end
      "5": begin pattern.bits = 5'b00000; pattern.len = 3'd5; end
      "6": begin pattern.bits = 5'b10000; pattern.len = 3'd5; end
      "7": begin pattern.bits = 5'b11000; pattern.len = 3'd5; end
      "8": begin pattern.bits = 5'b11100; pattern.len = 3'd5; end
      "9": begin pattern.bits = 5'b11110; pattern.len = 3'd5; end
      " ": pattern.is_space = 1'b1;
      default: pattern.known = 1'b0;
    endcase
  end

endmodule

// ----- src/mk_core.sv -----
module mk_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mk_pkg::TICK_W-1:0]      cfg_data,
  input  logic                           accept,
  input  logic                           mode,
  input  mk_pkg::pattern_t               pattern,
  output mk_pkg::result_t                result
);

  logic [mk_pkg::TICK_W-1:0] dot_ticks;
  logic [mk_pkg::TICK_W-1:0] dash_ticks;
  logic [mk_pkg::TICK_W-1:0] space_ticks;
  logic [mk_pkg::TICK_W-1:0] gap_ticks;

  mk_pkg::phase_t            phase, phase_next;
  logic [4:0]                code_bits, code_bits_next;
  logic [2:0]                code_left, code_left_next;
  logic                      space_pending, space_pending_next;
  logic [mk_pkg::TICK_W-1:0] tick_timer, tick_timer_next;

  logic                      idle;
  logic                      load;
  logic                      advance;
  logic                      start;
  logic [4:0]                src_bits;
  logic [2:0]                src_left;
  logic                      src_space;

  // a zero duration counts as one tick
  function automatic logic [mk_pkg::TICK_W-1:0] dur(input logic [mk_pkg::TICK_W-1:0] v);
    dur = (v == '0) ? mk_pkg::TICK_W'(1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks   <= mk_pkg::DOT_RESET;
      dash_ticks  <= mk_pkg::DASH_RESET;
      space_ticks <= mk_pkg::SPACE_RESET;
      gap_ticks   <= mk_pkg::GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mk_pkg::CFG_DOT:   dot_ticks   <= cfg_data;
        mk_pkg::CFG_DASH:  dash_ticks  <= cfg_data;
        mk_pkg::CFG_SPACE: space_ticks <= cfg_data;
        mk_pkg::CFG_GAP:   gap_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    idle    = (phase == mk_pkg::PH_IDLE);
    load    = accept && !mode && idle && pattern.known;
    // gap finished with elements still queued
    advance = accept && mode && (phase == mk_pkg::PH_GAP) && (tick_timer <= 12'd1)
              && ((code_left != 3'd0) || space_pending);
    start   = load || advance;

    src_bits  = load ? pattern.bits     : code_bits;
    src_left  = load ? pattern.len      : code_left;
    src_space = load ? pattern.is_space : space_pending;

    phase_next         = phase;
    code_bits_next     = code_bits;
    code_left_next     = code_left;
    space_pending_next = space_pending;
    tick_timer_next    = tick_timer;

    if (start) begin
      if (src_space) begin
        code_bits_next     = src_bits;
        code_left_next     = src_left;
        space_pending_next = 1'b0;
        phase_next         = mk_pkg::PH_DARK;
        tick_timer_next    = dur(space_ticks);
      end else begin
        code_bits_next     = {src_bits[3:0], 1'b0};
        code_left_next     = src_left - 3'd1;
        space_pending_next = 1'b0;
        phase_next         = mk_pkg::PH_MARK;
        tick_timer_next    = src_bits[4] ? dur(dash_ticks) : dur(dot_ticks);
      end
    end else if (accept && mode && !idle) begin
      if (tick_timer > 12'd1) begin
        tick_timer_next = tick_timer - 12'd1;
      end else if (phase != mk_pkg::PH_GAP) begin
        phase_next      = mk_pkg::PH_GAP;
        tick_timer_next = dur(gap_ticks);
      end else begin
        phase_next      = mk_pkg::PH_IDLE;
        tick_timer_next = '0;
      end
    end

    result.led_on   = (phase_next == mk_pkg::PH_MARK);
    result.busy_res = (phase_next != mk_pkg::PH_IDLE);
    result.rejected = accept && !mode && !idle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mk_pkg::PH_IDLE;
      code_bits     <= '0;
      code_left     <= '0;
      space_pending <= 1'b0;
      tick_timer    <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      code_bits     <= code_bits_next;
      code_left     <= code_left_next;
      space_pending <= space_pending_next;
      tick_timer    <= tick_timer_next;
    end
  end

endmodule

// ----- src/mk_outbuf.sv -----
module mk_outbuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mk_pkg::result_t push_data,
  output logic            push_ready,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mk_pkg::result_t pop_data
);

  mk_pkg::result_t slot0;
  mk_pkg::result_t slot1;
  logic [1:0]      count;
  logic            pop;

  assign pop        = pop_valid && pop_ready;
  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: if (push) count <= 2'd1;
        2'd1: begin
          if (push && !pop) count <= 2'd2;
          else if (pop && !push) count <= 2'd0;
        end
        2'd2: if (pop) count <= 2'd1;
        default: count <= 2'd0;
      endcase
    end
  end

  // payload slots, head in slot0
  always_ff @(posedge clk) begin
    case (count)
      2'd0: if (push) slot0 <= push_data;
      2'd1: begin
        if (push && pop) slot0 <= push_data;
        else if (push) slot1 <= push_data;
      end
      2'd2: if (pop) slot0 <= slot1;
      default: ;
    endcase
  end

endmodule

// ----- src/morse_keyer_unit.sv -----
// channel  role    payload
// req      sink    mode, char_code
// rsp      source  led_on, busy_res, rejected
// cfg      write   cfg_we, cfg_index, cfg_data
//
// one item per cycle while req.ready is high; the keyer state is updated at the transfer itself
// each result is written into a two-entry output buffer at the same edge as its transfer
// req.ready drops only when both buffer entries are full
// rst is synchronous: state idle, timing registers back to their defaults
module morse_keyer_unit (
  input  logic                          clk,
  input  logic                          rst,
  mk_req_if.sink                        req,
  mk_rsp_if.source                      rsp,
  input  logic                          cfg_we,
  input  logic [mk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mk_pkg::TICK_W-1:0]     cfg_data
);

  mk_pkg::pattern_t pattern;
  mk_pkg::result_t  result;
  mk_pkg::result_t  head;
  logic             accept;
  logic             buf_ready;

  assign accept    = req.valid && buf_ready;
  assign req.ready = buf_ready;

  mk_decode u_decode (
    .char_code (req.char_code),
    .pattern   (pattern)
  );

  mk_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .mode      (req.mode),
    .pattern   (pattern),
    .result    (result)
  );

  mk_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (result),
    .push_ready (buf_ready),
    .pop_valid  (rsp.valid),
    .pop_ready  (rsp.ready),
    .pop_data   (head)
  );

  assign rsp.led_on   = head.led_on;
  assign rsp.busy_res = head.busy_res;
  assign rsp.rejected = head.rejected;

endmodule

// ----- src/mk_checker.sv -----
`include "assert_macros.svh"

module mk_checker (
  input logic clk,
  input logic rst,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_led_on,
  input logic rsp_busy_res,
  input logic rsp_rejected
);

  // a lit led means a character is still playing
  `MK_ASSERT_IMPL(a_led_busy, clk, rst, rsp_valid && rsp_led_on, rsp_busy_res)
  // a dropped character leaves the keyer busy
  `MK_ASSERT_IMPL(a_rej_busy, clk, rst, rsp_valid && rsp_rejected, rsp_busy_res)
  // buffer comes out of reset empty
  `MK_ASSERT_ALWAYS_NEXT(a_rst_empty, clk, rst, !rsp_valid && req_ready)
  // a waiting result is not withdrawn
  `MK_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind morse_keyer_unit mk_checker u_mk_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_led_on   (rsp.led_on),
  .rsp_busy_res (rsp.busy_res),
  .rsp_rejected (rsp.rejected)
);
